@@ rtl/bmp_pkg.sv @@
// shared constants for the binomial coefficient mod prime core
// field widths, the prime modulus, barrett reduction constant, fermat exponent
// no dependencies
package bmp_pkg;

	localparam int TOP_W    = 63;
	localparam int CHOOSE_W = 7;
	localparam int VALUE_W  = 30;

	// prime modulus and its multiples used by the reducers
	localparam logic [VALUE_W-1:0] MODP    = 30'd1000000007;
	localparam logic [31:0]        MODP_2X = 32'd2000000014;

	// barrett constant floor(2^60 / p), fits in 31 bits
	localparam logic [63:0] BARRETT_NUM = 64'd1 << 60;
	localparam logic [31:0] BARRETT_MU  = 32'(BARRETT_NUM / 64'd1000000007);

	// 2^30 mod p, weight of each 30-bit slice when top is folded down
	localparam logic [VALUE_W-1:0] FOLD_C = 30'd73741817;

	// exponent p - 2 for the fermat inverse
	localparam logic [VALUE_W-1:0] FERMAT_EXP = 30'd1000000005;

endpackage

@@ rtl/binomial_mod_prime_core.sv @@
// top level of the binomial coefficient mod prime core
// sequencer around one shared modular multiplier (bmp_mulmod)
// depends on bmp_pkg and bmp_mulmod
//
// usage
//   command channel: drive top and choose and raise start; the beat is taken
//   at a rising edge with start high and busy low. busy stays high while the
//   item is worked on and no new beat is taken then.
//   result channel: value is shown for exactly one cycle with done high. the
//   receiver cannot stall, so it must take the beat in that cycle.
//   choose above MAX_CHOOSE is clamped to MAX_CHOOSE. top below the clamped
//   choose gives 1 in the cycle after the beat, and busy never rises.
// operation
//   otherwise top is first folded mod p in two modular multiplications by
//   2^30 mod p, each followed by adding the next 30-bit slice, then 2k + 31 + 15
//   modular multiplications follow; each runs in the shared multiplier and is
//   handed back to the sequencer before the next is issued, and each of the two
//   product loops ends with an idle step. the next beat can be taken at the edge
//   that ends the result cycle. the multiplier is the limiting unit.
// reset
//   arst_n clears the sequencer to idle and drops done; no clearing pass.
module binomial_mod_prime_core #(
	parameter int MAX_CHOOSE = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [bmp_pkg::TOP_W-1:0]      top,
	input  logic [bmp_pkg::CHOOSE_W-1:0]   choose,
	output logic                           busy,
	output logic                           done,
	output logic [bmp_pkg::VALUE_W-1:0]    value
);
	import bmp_pkg::*;

	// counter holds 0 .. MAX_CHOOSE + 1 for the factorial loop
	localparam int KW = $clog2(MAX_CHOOSE + 2);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RED  = 3'd1;  // top bits 62:60 folded with bits 59:30
	localparam logic [2:0] ST_NUM  = 3'd2;  // falling product of terms
	localparam logic [2:0] ST_DEN  = 3'd3;  // k factorial
	localparam logic [2:0] ST_PSQ  = 3'd4;  // square step of the inverse
	localparam logic [2:0] ST_PMUL = 3'd5;  // multiply step of the inverse
	localparam logic [2:0] ST_FIN  = 3'd6;  // numerator times inverse
	localparam logic [2:0] ST_RED2 = 3'd7;  // low 30 bits of top folded in

	// control
	logic [2:0]   state_q;
	logic         pend_q;
	logic         done_q;
	// working registers
	logic [2*VALUE_W-1:0] n_q;
	logic [VALUE_W-1:0] red_q;
	logic [KW-1:0]      k_q;
	logic [KW-1:0]      cnt_q;
	logic [4:0]         bit_q;
	logic [VALUE_W-1:0] t_q;
	logic [VALUE_W-1:0] num_q;
	logic [VALUE_W-1:0] den_q;
	logic [VALUE_W-1:0] acc_q;
	logic [VALUE_W-1:0] value_q;

	logic [KW-1:0]      k_sat;
	logic               below;
	logic               accept;
	logic [VALUE_W-1:0] fold_lo;
	logic [VALUE_W:0]   fold_sum;
	logic [VALUE_W-1:0] fold_next;
	logic [VALUE_W-1:0] t_next;
	logic               mul_state;
	logic               loop_end;
	logic               mm_go;
	logic               mm_done;
	logic [VALUE_W-1:0] mm_a;
	logic [VALUE_W-1:0] mm_b;
	logic [VALUE_W-1:0] mm_res;

	// clamp choose, then test top below it
	always_comb begin
		if (32'(choose) > 32'(MAX_CHOOSE)) begin
			k_sat = KW'(MAX_CHOOSE);
		end else begin
			k_sat = KW'(choose);
		end
	end

	assign below  = top < TOP_W'(k_sat);
	assign accept = start && !busy;

	// add the next 30-bit slice of top to the folded part, sum stays below 3p
	assign fold_lo  = (state_q == ST_RED) ? n_q[2*VALUE_W-1:VALUE_W] : n_q[VALUE_W-1:0];
	assign fold_sum = {1'b0, mm_res} + {1'b0, fold_lo};

	always_comb begin
		if (fold_sum >= (VALUE_W+1)'(MODP_2X)) begin
			fold_next = VALUE_W'(fold_sum - (VALUE_W+1)'(MODP_2X));
		end else if (fold_sum >= (VALUE_W+1)'(MODP)) begin
			fold_next = VALUE_W'(fold_sum - (VALUE_W+1)'(MODP));
		end else begin
			fold_next = fold_sum[VALUE_W-1:0];
		end
	end

	// next numerator term: one less, wrapping through zero to p - 1
	assign t_next = (t_q == '0) ? (MODP - VALUE_W'(1)) : (t_q - VALUE_W'(1));

	assign mul_state = (state_q == ST_RED) || (state_q == ST_RED2) ||
		(state_q == ST_NUM) || (state_q == ST_DEN) ||
		(state_q == ST_PSQ) || (state_q == ST_PMUL) || (state_q == ST_FIN);
	assign loop_end = ((state_q == ST_NUM) && (cnt_q == k_q)) ||
		((state_q == ST_DEN) && (cnt_q > k_q));
	assign mm_go = mul_state && !pend_q && !loop_end;

	// operands for the shared multiplier, held steady while it runs
	always_comb begin
		case (state_q)
			ST_RED, ST_RED2: begin
				mm_a = red_q;
				mm_b = FOLD_C;
			end
			ST_NUM: begin
				mm_a = num_q;
				mm_b = t_q;
			end
			ST_DEN: begin
				mm_a = den_q;
				mm_b = VALUE_W'(cnt_q);
			end
			ST_PSQ: begin
				mm_a = acc_q;
				mm_b = acc_q;
			end
			ST_PMUL: begin
				mm_a = acc_q;
				mm_b = den_q;
			end
			ST_FIN: begin
				mm_a = num_q;
				mm_b = acc_q;
			end
			default: begin
				mm_a = num_q;
				mm_b = acc_q;
			end
		endcase
	end

	bmp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mm_go),
		.a      (mm_a),
		.b      (mm_b),
		.done   (mm_done),
		.res    (mm_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (mm_go) begin
				pend_q <= 1'b1;
			end else if (mm_done) begin
				pend_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (below) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_RED;
						end
					end
				end
				ST_RED: begin
					if (mm_done) state_q <= ST_RED2;
				end
				ST_RED2: begin
					if (mm_done) state_q <= ST_NUM;
				end
				ST_NUM: begin
					if (loop_end) state_q <= ST_DEN;
				end
				ST_DEN: begin
					if (loop_end) state_q <= ST_PSQ;
				end
				ST_PSQ: begin
					if (mm_done) begin
						if (FERMAT_EXP[bit_q]) begin
							state_q <= ST_PMUL;
						end else if (bit_q == '0) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_PMUL: begin
					if (mm_done) begin
						state_q <= (bit_q == '0) ? ST_FIN : ST_PSQ;
					end
				end
				ST_FIN: begin
					if (mm_done) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					n_q     <= top[2*VALUE_W-1:0];
					k_q     <= k_sat;
					red_q   <= VALUE_W'(top[TOP_W-1:2*VALUE_W]);
					cnt_q   <= '0;
					num_q   <= VALUE_W'(1);
					den_q   <= VALUE_W'(1);
					acc_q   <= VALUE_W'(1);
					bit_q   <= 5'(VALUE_W - 1);
					value_q <= VALUE_W'(1);
				end
			end
			ST_RED: begin
				if (mm_done) red_q <= fold_next;
			end
			ST_RED2: begin
				if (mm_done) t_q <= fold_next;
			end
			ST_NUM: begin
				if (loop_end) begin
					cnt_q <= KW'(1);
				end else if (mm_done) begin
					num_q <= mm_res;
					t_q   <= t_next;
					cnt_q <= cnt_q + KW'(1);
				end
			end
			ST_DEN: begin
				if (mm_done) begin
					den_q <= mm_res;
					cnt_q <= cnt_q + KW'(1);
				end
			end
			ST_PSQ: begin
				if (mm_done) begin
					acc_q <= mm_res;
					if (!FERMAT_EXP[bit_q] && bit_q != '0) bit_q <= bit_q - 5'd1;
				end
			end
			ST_PMUL: begin
				if (mm_done) begin
					acc_q <= mm_res;
					if (bit_q != '0) bit_q <= bit_q - 5'd1;
				end
			end
			ST_FIN: begin
				if (mm_done) value_q <= mm_res;
			end
			default: ;
		endcase
	end

	assign busy  = state_q != ST_IDLE;
	assign done  = done_q;
	assign value = value_q;

	a_busy_ends_with_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result beat");

	a_value_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> value < MODP)
		else $error("result not reduced mod p");

	a_below_gives_one: assert property (@(posedge clk) disable iff (!arst_n)
		accept && below |=> done && value == VALUE_W'(1) && !busy)
		else $error("top below choose must give one at once");

	a_done_only_when_pending: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> pend_q && mul_state)
		else $error("multiplier result with no request outstanding");

endmodule

@@ rtl/bmp_mulmod.sv @@
// shared modular multiplier: a * b mod p through the product, barrett, subtract and fix phases
// one 32x32 multiplier reused for the product and the two barrett steps
// depends on bmp_pkg
module bmp_mulmod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [bmp_pkg::VALUE_W-1:0] a,
	input  logic [bmp_pkg::VALUE_W-1:0] b,
	output logic                        done,
	output logic [bmp_pkg::VALUE_W-1:0] res
);
	import bmp_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_BAR  = 2'd1;
	localparam logic [1:0] PH_SUB  = 2'd2;
	localparam logic [1:0] PH_FIX  = 2'd3;

	logic [1:0]         phase_q;
	logic               done_q;
	logic [59:0]        x_q;
	logic [29:0]        q3_q;
	logic [31:0]        r_q;
	logic [VALUE_W-1:0] res_q;

	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;
	logic [31:0] r_fix;

	// operand select for the one multiplier
	always_comb begin
		case (phase_q)
			PH_BAR: begin
				op_a = 32'(x_q[59:29]);
				op_b = BARRETT_MU;
			end
			PH_SUB: begin
				op_a = 32'(q3_q);
				op_b = 32'(MODP);
			end
			default: begin
				op_a = 32'(a);
				op_b = 32'(b);
			end
		endcase
	end

	assign prod = 64'(op_a) * 64'(op_b);

	// barrett remainder lies below 3p
	always_comb begin
		if (r_q >= MODP_2X) begin
			r_fix = r_q - MODP_2X;
		end else if (r_q >= 32'(MODP)) begin
			r_fix = r_q - 32'(MODP);
		end else begin
			r_fix = r_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (go) phase_q <= PH_BAR;
				end
				PH_BAR: phase_q <= PH_SUB;
				PH_SUB: phase_q <= PH_FIX;
				PH_FIX: begin
					phase_q <= PH_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (go) x_q <= prod[59:0];
			end
			PH_BAR: q3_q <= prod[60:31];
			PH_SUB: r_q <= x_q[31:0] - prod[31:0];
			PH_FIX: res_q <= r_fix[VALUE_W-1:0];
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> phase_q == PH_IDLE)
		else $error("mulmod started while busy");

	a_done_after_fix: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(phase_q) == PH_FIX)
		else $error("mulmod done without a fix phase");

endmodule

@@ bench/tb.sv @@
// testbench for binomial_mod_prime_core: a table of corner commands, then random commands
// every result beat is checked against a known table value or a behavioural C(n,k) mod p predictor
// depends on bmp_pkg and binomial_mod_prime_core
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_CHOOSE   = 64;
	localparam int ITEMS        = 1200;
	localparam int QUIET_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 1100;
	localparam int REPORT_MAX   = 10;
	localparam logic [63:0] PRIME = 64'(bmp_pkg::MODP);
	localparam logic [bmp_pkg::TOP_W-1:0] TOP_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [bmp_pkg::TOP_W-1:0]    top;
		logic [bmp_pkg::CHOOSE_W-1:0] choose;
		logic                         known;
		logic [bmp_pkg::VALUE_W-1:0]  fixed;
	} corner_cmd_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          start;
	logic [bmp_pkg::TOP_W-1:0]     top;
	logic [bmp_pkg::CHOOSE_W-1:0]  choose;
	logic                          busy;
	logic                          done;
	logic [bmp_pkg::VALUE_W-1:0]   value;

	// expected binomials, oldest first
	logic [bmp_pkg::VALUE_W-1:0] binom_q [$];
	int mismatches = 0;
	int quiet_cycles = 0;

	// known values only where they are obvious, the rest go to the predictor
	corner_cmd_t corner_cmds [23] = '{
		'{63'd0,          7'd0,   1'b1, 30'd1},    // empty product
		'{63'd0,          7'd1,   1'b1, 30'd1},    // top below choose
		'{63'd5,          7'd2,   1'b1, 30'd10},
		'{63'd7,          7'd3,   1'b1, 30'd35},
		'{63'd100,        7'd1,   1'b1, 30'd100},
		'{63'd64,         7'd64,  1'b1, 30'd1},
		'{63'd65,         7'd127, 1'b1, 30'd65},   // choose clamps to 64
		'{63'd63,         7'd127, 1'b1, 30'd1},    // below the clamped choose
		'{63'd64,         7'd127, 1'b1, 30'd1},
		'{63'd1,          7'd65,  1'b1, 30'd1},
		'{TOP_MAX,        7'd0,   1'b1, 30'd1},
		'{TOP_MAX,        7'd1,   1'b0, 30'd0},
		'{TOP_MAX,        7'd64,  1'b0, 30'd0},
		'{TOP_MAX,        7'd127, 1'b0, 30'd0},
		'{63'd1000000007, 7'd1,   1'b1, 30'd0},    // term equal to p
		'{63'd1000000012, 7'd10,  1'b1, 30'd0},    // p inside the product
		'{63'd2000000014, 7'd64,  1'b1, 30'd0},    // 2p heads the product
		'{63'd1000000006, 7'd2,   1'b0, 30'd0},
		'{63'd1000000006, 7'd64,  1'b0, 30'd0},
		'{63'd1000000071, 7'd64,  1'b0, 30'd0},    // just clear of p
		'{63'h2AAA_AAAA_AAAA_AAAA, 7'h55, 1'b0, 30'd0},
		'{63'h5555_5555_5555_5555, 7'h2A, 1'b0, 30'd0},
		'{63'h4000_0000_0000_0000, 7'h40, 1'b0, 30'd0}
	};

	binomial_mod_prime_core #(
		.MAX_CHOOSE(MAX_CHOOSE)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.top    (top),
		.choose (choose),
		.busy   (busy),
		.done   (done),
		.value  (value)
	);

	always #6 clk = ~clk;

	function automatic logic [63:0] mul_mod_p(input logic [63:0] a, input logic [63:0] b);
		return ((a % PRIME) * (b % PRIME)) % PRIME;
	endfunction

	// numerator times the fermat inverse of choose!
	function automatic logic [bmp_pkg::VALUE_W-1:0] binom_mod_p(
		input logic [bmp_pkg::TOP_W-1:0] n_in,
		input logic [bmp_pkg::CHOOSE_W-1:0] k_in
	);
		logic [63:0] n, k, i, num, den, sq, acc, e, r;
		n = 64'(n_in);
		k = 64'(k_in);
		if (k > 64'(MAX_CHOOSE))
			k = 64'(MAX_CHOOSE);
		if (n < k)
			return bmp_pkg::VALUE_W'(1);
		num = 1;
		den = 1;
		for (i = 0; i < k; i++)
			num = mul_mod_p(num, n - i);
		for (i = 1; i <= k; i++)
			den = mul_mod_p(den, i);
		acc = 1;
		sq = den;
		e = 64'(bmp_pkg::FERMAT_EXP);
		while (e != 0) begin
			if (e[0])
				acc = mul_mod_p(acc, sq);
			e = e >> 1;
			sq = mul_mod_p(sq, sq);
		end
		r = mul_mod_p(num, acc);
		return r[bmp_pkg::VALUE_W-1:0];
	endfunction

	// one command beat, with an optional random gap ahead of it
	task automatic issue(
		input logic [bmp_pkg::TOP_W-1:0]    t,
		input logic [bmp_pkg::CHOOSE_W-1:0] c,
		input logic                         known,
		input logic [bmp_pkg::VALUE_W-1:0]  fixed,
		input bit                           may_idle
	);
		if (may_idle && $urandom_range(99) < 15) begin
			start <= 1'b0;
			repeat ($urandom_range(1, $urandom_range(1) ? 8 : 1000)) @(posedge clk);
		end
		start  <= 1'b1;
		top    <= t;
		choose <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		binom_q.push_back(known ? fixed : binom_mod_p(t, c));
	endtask

	// hold off until every outstanding result has come back
	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (binom_q.size() != 0);
	endtask

	initial begin
		logic [bmp_pkg::TOP_W-1:0]    t;
		logic [bmp_pkg::CHOOSE_W-1:0] c;
		int sel;
		arst_n = 1'b0;
		start  = 1'b0;
		top    = '0;
		choose = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_cmds[r])
			issue(corner_cmds[r].top, corner_cmds[r].choose, corner_cmds[r].known,
				corner_cmds[r].fixed, 1'b1);
		drain();

		for (int n = 0; n < ITEMS; n++) begin
			if (n == ITEMS / 2)
				drain();
			// mostly small choose keeps the run short, 12 percent clamp
			sel = $urandom_range(99);
			if (sel < 70)
				c = 7'($urandom_range(0, 6));
			else if (sel < 88)
				c = 7'($urandom_range(0, MAX_CHOOSE));
			else
				c = 7'($urandom_range(MAX_CHOOSE + 1, 127));
			sel = $urandom_range(99);
			if (sel < 40)
				t = 63'({$urandom, $urandom});
			else if (sel < 55)
				t = 63'($urandom_range(0, 80));
			else if (sel < 75)
				t = 63'(64'($urandom) * PRIME + 64'($urandom_range(0, 70)));
			else if (sel < 85)
				t = TOP_MAX - 63'($urandom_range(0, 200));
			else
				t = 63'($urandom);
			// a long stretch of back-to-back commands in the first half
			issue(t, c, 1'b0, '0, !(n >= 300 && n < 600));
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && binom_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// result beats cannot be held off, so every done is compared at once
	always @(posedge clk) begin
		if (done) begin
			if (binom_q.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("%0t: unexpected result beat, value %0d", $realtime, value);
				mismatches++;
			end else begin
				if (value !== binom_q[0]) begin
					if (mismatches < REPORT_MAX)
						$display("%0t: value mismatch, expected %0d actual %0d",
							$realtime, binom_q[0], value);
					mismatches++;
				end
				void'(binom_q.pop_front());
			end
		end
	end

	// watchdog on cycles with neither a command beat nor a result beat
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles = 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else
			quiet_cycles++;
	end

endmodule

@@ files.f @@
rtl/bmp_pkg.sv
rtl/bmp_mulmod.sv
rtl/binomial_mod_prime_core.sv
bench/tb.sv
